// File: rtl/calendar_date_offset_unit_assert.svh
// Assertion macros for the calendar date offset unit.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef CALENDAR_DATE_OFFSET_UNIT_ASSERT_SVH
`define CALENDAR_DATE_OFFSET_UNIT_ASSERT_SVH

// Antecedent this cycle, consequent in the same cycle.
`define CDO_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calendar date offset unit: assertion failed");

// Antecedent this cycle, consequent in the next cycle.
`define CDO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calendar date offset unit: assertion failed");

`endif

// File: rtl/cdo_pkg.sv
// Shared types, codes and calendar helpers for the calendar date offset unit.
// No dependencies.
package cdo_pkg;

	// operation codes
	localparam logic [1:0] MODE_VALIDATE = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_SUB      = 2'd2;
	localparam logic [1:0] MODE_CMP      = 2'd3;

	localparam int YEAR_CYCLE = 400;
	localparam int CENTURY    = 100;

	localparam logic [3:0] FIRST_MONTH = 4'd1;
	localparam logic [3:0] LAST_MONTH  = 4'd12;
	localparam logic [4:0] FIRST_DAY   = 5'd1;
	localparam logic [4:0] DEC_DAYS    = 5'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_STEP,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic reduce;
		logic check;
		logic step;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic red_last;
		logic need_step;
		logic step_last;
	} sts_t;

	// leap year from year mod 4 and year mod 400
	function automatic logic is_leap(input logic [1:0] ylo, input logic [8:0] r400);
		return (ylo == 2'd0) && !((r400 == 9'(CENTURY)) || (r400 == 9'(2 * CENTURY)) ||
			(r400 == 9'(3 * CENTURY)));
	endfunction

	// 0 for a month code outside 1..12
	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2: n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/calendar_date_offset_unit.sv
// Gregorian date offset and compare unit.
// One word in: mode, a first date, a day count and a second date.
// One word out per word in: result date and flags.
// Mode 0 validates the first date, mode 1 adds day_count days, mode 2
// subtracts them, mode 3 compares the first date with the second.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. in_stall is low only while the unit is idle.
// Sequence: accept, reduce the year mod 400 (one restoring subtract per
// cycle), check, month steps, then load the output register. There are
// no month steps for validate, compare, invalid dates and a zero count;
// otherwise there is one per month crossed plus one. The month stepper
// moves one month per cycle.
// A new word is taken while the previous result still sits in the output
// register. When the receiver stalls, the result holds; a finished item
// waits for the register to free up before the unit goes idle again.
// Reset clears the controller and the output valid; no memory to clear.
// Years leaving 1..2^YEAR_BITS-1 saturate and raise year_overflow.
module calendar_date_offset_unit #(
	parameter int YEAR_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [4:0]            day,
	input  logic [3:0]            month,
	input  logic [YEAR_BITS-1:0]  year,
	input  logic [COUNT_BITS-1:0] day_count,
	input  logic [4:0]            other_day,
	input  logic [3:0]            other_month,
	input  logic [YEAR_BITS-1:0]  other_year,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [4:0]            result_day,
	output logic [3:0]            result_month,
	output logic [YEAR_BITS-1:0]  result_year,
	output logic                  date_ok,
	output logic                  is_less,
	output logic                  is_equal,
	output logic                  year_overflow
);
	import cdo_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing and handshakes
	cdo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// operands, year reduction, month stepper and result register
	cdo_dpath #(
		.YEAR_BITS  (YEAR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.day           (day),
		.month         (month),
		.year          (year),
		.day_count     (day_count),
		.other_day     (other_day),
		.other_month   (other_month),
		.other_year    (other_year),
		.result_day    (result_day),
		.result_month  (result_month),
		.result_year   (result_year),
		.date_ok       (date_ok),
		.is_less       (is_less),
		.is_equal      (is_equal),
		.year_overflow (year_overflow)
	);

endmodule

// File: rtl/cdo_dpath.sv
// Datapath: operand registers, year mod 400 reduction, month stepper, result register.
// Depends on cdo_pkg.
module cdo_dpath #(
	parameter int YEAR_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  cdo_pkg::cmd_t         cmd,
	output cdo_pkg::sts_t         sts,
	input  logic [1:0]            mode,
	input  logic [4:0]            day,
	input  logic [3:0]            month,
	input  logic [YEAR_BITS-1:0]  year,
	input  logic [COUNT_BITS-1:0] day_count,
	input  logic [4:0]            other_day,
	input  logic [3:0]            other_month,
	input  logic [YEAR_BITS-1:0]  other_year,
	output logic [4:0]            result_day,
	output logic [3:0]            result_month,
	output logic [YEAR_BITS-1:0]  result_year,
	output logic                  date_ok,
	output logic                  is_less,
	output logic                  is_equal,
	output logic                  year_overflow
);
	import cdo_pkg::*;

	localparam int SUM_BITS = COUNT_BITS + 1;
	// largest 400 * 2^k that fits the year width
	localparam logic [YEAR_BITS-1:0] DV_START = YEAR_BITS'(YEAR_CYCLE) << (YEAR_BITS - 9);
	localparam logic [YEAR_BITS-1:0] DV_LAST  = YEAR_BITS'(YEAR_CYCLE);
	localparam logic [YEAR_BITS-1:0] R_TOP    = YEAR_BITS'(YEAR_CYCLE - 1);

	logic [1:0]            mode_q;
	logic [4:0]            d_q, od_q;
	logic [3:0]            m_q, om_q;
	logic [YEAR_BITS-1:0]  y_q, oy_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [YEAR_BITS-1:0]  red_q;   // year mod 400 once reduced
	logic [YEAR_BITS-1:0]  dv_q;
	logic                  ok_q, ovf_q;

	logic [4:0]            res_day_q;
	logic [3:0]            res_month_q;
	logic [YEAR_BITS-1:0]  res_year_q;
	logic                  res_ok_q, res_less_q, res_equal_q, res_ovf_q;

	logic                  leap;
	logic [4:0]            dim, prev_dim;
	logic                  ok_c;
	logic [SUM_BITS-1:0]   sum;
	logic [4:0]            d_n;
	logic [3:0]            m_n;
	logic [YEAR_BITS-1:0]  y_n, red_n;
	logic [COUNT_BITS-1:0] rem_n;
	logic                  ovf_n, step_last;
	logic                  less_c, equal_c;

	always_comb begin
		leap     = is_leap(y_q[1:0], red_q[8:0]);
		dim      = days_in_month(m_q, leap);
		prev_dim = days_in_month(m_q - 4'd1, leap);
		ok_c     = (y_q != '0) && (dim != 5'd0) && (d_q != 5'd0) && (d_q <= dim);
		sum      = {1'b0, rem_q} + SUM_BITS'(d_q);

		d_n       = d_q;
		m_n       = m_q;
		y_n       = y_q;
		red_n     = red_q;
		rem_n     = rem_q;
		ovf_n     = 1'b0;
		step_last = 1'b0;
		if (mode_q == MODE_ADD) begin
			if (sum <= SUM_BITS'(dim)) begin
				d_n       = sum[4:0];
				step_last = 1'b1;
			end else begin
				rem_n = rem_q - COUNT_BITS'(dim - d_q + 5'd1);
				d_n   = FIRST_DAY;
				if (m_q == LAST_MONTH) begin
					if (y_q == '1) begin
						// past the last representable year
						d_n       = DEC_DAYS;
						m_n       = LAST_MONTH;
						ovf_n     = 1'b1;
						step_last = 1'b1;
					end else begin
						m_n   = FIRST_MONTH;
						y_n   = y_q + YEAR_BITS'(1);
						red_n = (red_q == R_TOP) ? '0 : red_q + YEAR_BITS'(1);
					end
				end else begin
					m_n = m_q + 4'd1;
				end
			end
		end else begin
			if (rem_q < COUNT_BITS'(d_q)) begin
				d_n       = d_q - rem_q[4:0];
				step_last = 1'b1;
			end else begin
				rem_n = rem_q - COUNT_BITS'(d_q);
				if (m_q == FIRST_MONTH) begin
					if (y_q == YEAR_BITS'(1)) begin
						// before January 1 of year 1
						d_n       = FIRST_DAY;
						ovf_n     = 1'b1;
						step_last = 1'b1;
					end else begin
						d_n   = DEC_DAYS;
						m_n   = LAST_MONTH;
						y_n   = y_q - YEAR_BITS'(1);
						red_n = (red_q == '0) ? R_TOP : red_q - YEAR_BITS'(1);
					end
				end else begin
					d_n = prev_dim;
					m_n = m_q - 4'd1;
				end
			end
		end

		less_c  = (y_q < oy_q) || ((y_q == oy_q) && (m_q < om_q)) ||
			((y_q == oy_q) && (m_q == om_q) && (d_q < od_q));
		equal_c = (y_q == oy_q) && (m_q == om_q) && (d_q == od_q);

		sts.red_last  = (dv_q == DV_LAST);
		sts.step_last = step_last;
		case (mode_q)
			MODE_ADD, MODE_SUB:      sts.need_step = ok_c && (rem_q != '0);
			MODE_VALIDATE, MODE_CMP: sts.need_step = 1'b0;
			default:                 sts.need_step = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			d_q    <= day;
			m_q    <= month;
			y_q    <= year;
			rem_q  <= day_count;
			od_q   <= other_day;
			om_q   <= other_month;
			oy_q   <= other_year;
			red_q  <= year;
			dv_q   <= DV_START;
			ovf_q  <= 1'b0;
		end
		if (cmd.reduce) begin
			if (red_q >= dv_q) begin
				red_q <= red_q - dv_q;
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.check) begin
			ok_q <= ok_c;
		end
		if (cmd.step) begin
			d_q   <= d_n;
			m_q   <= m_n;
			y_q   <= y_n;
			red_q <= red_n;
			rem_q <= rem_n;
			ovf_q <= ovf_n;
		end
		if (cmd.out_load) begin
			res_day_q   <= d_q;
			res_month_q <= m_q;
			res_year_q  <= y_q;
			res_ok_q    <= ok_q;
			res_less_q  <= (mode_q == MODE_CMP) && less_c;
			res_equal_q <= (mode_q == MODE_CMP) && equal_c;
			res_ovf_q   <= ovf_q;
		end
	end

	assign result_day    = res_day_q;
	assign result_month  = res_month_q;
	assign result_year   = res_year_q;
	assign date_ok       = res_ok_q;
	assign is_less       = res_less_q;
	assign is_equal      = res_equal_q;
	assign year_overflow = res_ovf_q;

endmodule

// File: rtl/cdo_ctrl.sv
// Controller: sequences reduce, check and month steps, owns the handshakes.
// Depends on cdo_pkg and calendar_date_offset_unit_assert.svh.
`include "calendar_date_offset_unit_assert.svh"

module cdo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output cdo_pkg::cmd_t cmd,
	input  cdo_pkg::sts_t sts
);
	import cdo_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_n = ST_REDUCE;
			ST_REDUCE: if (sts.red_last) state_n = ST_CHECK;
			ST_CHECK:  state_n = sts.need_step ? ST_STEP : ST_DONE;
			ST_STEP:   if (sts.step_last) state_n = ST_DONE;
			ST_DONE:   if (out_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_REDUCE: cmd.reduce   = 1'b1;
			ST_CHECK:  cmd.check    = 1'b1;
			ST_STEP:   cmd.step     = 1'b1;
			ST_DONE:   cmd.out_load = out_free;
			default:   cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`CDO_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_q == ST_REDUCE)
	`CDO_ASSERT_NEXT(a_step_holds, (state_q == ST_STEP) && !sts.step_last, state_q == ST_STEP)
	`CDO_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid)
	`CDO_ASSERT_NOW(a_done_waits, (state_q == ST_DONE) && out_valid_q && out_stall, !cmd.out_load)

endmodule

// File: tb/calendar_date_offset_unit_tb.sv
// Testbench for calendar_date_offset_unit: directed probe table, then random date words,
// each checked against a typed-in result or a Gregorian predictor kept in this file.
// Depends on cdo_pkg (mode codes) and the unit itself.
`timescale 1ns / 100ps

module calendar_date_offset_unit_tb;
	import cdo_pkg::*;

	localparam int YEAR_W = 16;
	localparam int COUNT_W = 16;
	localparam logic [YEAR_W-1:0] YEAR_TOP = '1;
	localparam int RANDOM_WORDS = 230;
	// a 16-bit count walks about 2200 months; the run stays far below this
	localparam int CYCLE_LIMIT = 4000000;
	// quiet cycles after the last result: covers accept, year reduce, check, output
	localparam int DRAIN_CYCLES = 64;
	// long receiver hold-off so the output register and the stepper both fill up
	localparam int HOLD_CYCLES = 600;

	// one input word
	typedef struct packed {
		logic [1:0]         mode;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] count;
		logic [4:0]         other_day;
		logic [3:0]         other_month;
		logic [YEAR_W-1:0]  other_year;
	} date_word_t;

	// one output word
	typedef struct packed {
		logic [4:0]        day;
		logic [3:0]        month;
		logic [YEAR_W-1:0] year;
		logic              ok;
		logic              less;
		logic              equal;
		logic              ovf;
	} date_result_t;

	// directed probe: word, and a typed-in result where it is obvious
	typedef struct packed {
		date_word_t   word;
		logic         known;
		date_result_t want;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] mode;
	logic [4:0] day;
	logic [3:0] month;
	logic [YEAR_W-1:0] year;
	logic [COUNT_W-1:0] day_count;
	logic [4:0] other_day;
	logic [3:0] other_month;
	logic [YEAR_W-1:0] other_year;
	logic out_valid;
	logic out_stall;
	logic [4:0] result_day;
	logic [3:0] result_month;
	logic [YEAR_W-1:0] result_year;
	logic date_ok;
	logic is_less;
	logic is_equal;
	logic year_overflow;

	date_result_t expected_dates[$];
	date_result_t want_date;
	int unsigned mismatch_count = 0;
	int unsigned dates_returned = 0;
	int unsigned cycles = 0;
	bit no_gaps = 1'b0;

	always #5 clk = ~clk;

	calendar_date_offset_unit #(
		.YEAR_BITS (YEAR_W),
		.COUNT_BITS(COUNT_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.day          (day),
		.month        (month),
		.year         (year),
		.day_count    (day_count),
		.other_day    (other_day),
		.other_month  (other_month),
		.other_year   (other_year),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.date_ok      (date_ok),
		.is_less      (is_less),
		.is_equal     (is_equal),
		.year_overflow(year_overflow)
	);

	// ------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------

	// divisible by 4, except centuries not divisible by 400
	function automatic bit leap_year(input longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// 0 for month codes outside 1..12
	function automatic int unsigned month_length(input int unsigned m,
			input longint unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return leap_year(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_is_real(input int unsigned d, input int unsigned m,
			input longint unsigned y);
		return (y != 0) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_length(m, y));
	endfunction

	// day number, January 1 of year 1 is day 1; date must be real
	function automatic longint unsigned day_number(input int unsigned d, input int unsigned m,
			input longint unsigned y);
		longint unsigned past;
		longint unsigned n;
		past = y - 1;
		n = past * 365 + past / 4 - past / 100 + past / 400;
		for (int unsigned k = 1; k < m; k++)
			n += month_length(k, y);
		return n + d;
	endfunction

	// inverse of day_number: split off 400-year eras, centuries, 4-year runs, years
	function automatic void date_of_number(input longint unsigned n, output logic [4:0] d,
			output logic [3:0] m, output logic [YEAR_W-1:0] y);
		longint unsigned rest;
		longint unsigned eras;
		longint unsigned cents;
		longint unsigned quads;
		longint unsigned years;
		longint unsigned full_year;
		int unsigned k;
		rest = n - 1;
		eras = rest / 146097;
		rest = rest % 146097;
		cents = rest / 36524;
		if (cents > 3)
			cents = 3;	// last day of a 400-year era
		rest -= cents * 36524;
		quads = rest / 1461;
		rest = rest % 1461;
		years = rest / 365;
		if (years > 3)
			years = 3;	// Dec 31 of a leap year
		rest -= years * 365;
		full_year = eras * 400 + cents * 100 + quads * 4 + years + 1;
		k = 1;
		while (k < 12 && rest >= month_length(k, full_year)) begin
			rest -= month_length(k, full_year);
			k++;
		end
		d = 5'(rest + 1);
		m = 4'(k);
		y = YEAR_W'(full_year);
	endfunction

	function automatic date_result_t predict_date_op(input date_word_t w);
		date_result_t r;
		longint unsigned here;
		r = '0;
		r.day = w.day;
		r.month = w.month;
		r.year = w.year;
		r.ok = date_is_real(w.day, w.month, w.year);
		if (w.mode == MODE_CMP) begin
			// raw fields, year first, valid or not
			r.less = (w.year < w.other_year) ||
				(w.year == w.other_year && w.month < w.other_month) ||
				(w.year == w.other_year && w.month == w.other_month && w.day < w.other_day);
			r.equal = (w.year == w.other_year) && (w.month == w.other_month) &&
				(w.day == w.other_day);
		end else if (r.ok && w.count != 0 && w.mode == MODE_ADD) begin
			here = day_number(w.day, w.month, w.year) + w.count;
			if (here > day_number(31, 12, YEAR_TOP)) begin
				// past Dec 31 of the top year: saturate
				r.ovf = 1'b1;
				r.day = 5'd31;
				r.month = 4'd12;
				r.year = YEAR_TOP;
			end else begin
				date_of_number(here, r.day, r.month, r.year);
			end
		end else if (r.ok && w.count != 0 && w.mode == MODE_SUB) begin
			here = day_number(w.day, w.month, w.year);
			if (w.count >= here) begin
				// before Jan 1 of year 1: saturate
				r.ovf = 1'b1;
				r.day = 5'd1;
				r.month = 4'd1;
				r.year = YEAR_W'(1);
			end else begin
				date_of_number(here - w.count, r.day, r.month, r.year);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed probes
	// word: mode, day, month, year, count, other day, month, year
	// result: day, month, year, ok, less, equal, overflow
	// ------------------------------------------------------------------
	probe_row_t probe_rows [0:24] = '{
		// leap rule: by 400, by 100, by 4, plain year
		'{'{MODE_VALIDATE, 5'd29, 4'd2, 16'd2000, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd29, 4'd2, 16'd2000, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_VALIDATE, 5'd29, 4'd2, 16'd1900, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd29, 4'd2, 16'd1900, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_VALIDATE, 5'd29, 4'd2, 16'd2024, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd29, 4'd2, 16'd2024, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_VALIDATE, 5'd29, 4'd2, 16'd2023, 16'hffff, 5'd31, 4'd15, 16'hffff}, 1'b1,
			'{5'd29, 4'd2, 16'd2023, 1'b0, 1'b0, 1'b0, 1'b0}},
		// all-zero and all-ones fields
		'{'{MODE_VALIDATE, 5'd0, 4'd0, 16'd0, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd0, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_VALIDATE, 5'd31, 4'd15, 16'hffff, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd31, 4'd15, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0}},
		// day 31 in a 30-day month
		'{'{MODE_VALIDATE, 5'd31, 4'd4, 16'd2021, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd31, 4'd4, 16'd2021, 1'b0, 1'b0, 1'b0, 1'b0}},
		// add past the top year saturates
		'{'{MODE_ADD, 5'd31, 4'd12, 16'hffff, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd31, 4'd12, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b1}},
		// largest count from the first day
		'{'{MODE_ADD, 5'd1, 4'd1, 16'd1, 16'hffff, 5'd0, 4'd0, 16'd0}, 1'b0, '0},
		'{'{MODE_ADD, 5'd28, 4'd2, 16'd2024, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd29, 4'd2, 16'd2024, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_ADD, 5'd28, 4'd2, 16'd2023, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd1, 4'd3, 16'd2023, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_ADD, 5'd31, 4'd12, 16'd1999, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd1, 4'd1, 16'd2000, 1'b1, 1'b0, 1'b0, 1'b0}},
		// zero count returns the date as is
		'{'{MODE_ADD, 5'd15, 4'd6, 16'd2020, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd15, 4'd6, 16'd2020, 1'b1, 1'b0, 1'b0, 1'b0}},
		// invalid date passes through, no overflow
		'{'{MODE_ADD, 5'd30, 4'd2, 16'd2020, 16'd10, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd30, 4'd2, 16'd2020, 1'b0, 1'b0, 1'b0, 1'b0}},
		// subtract before year 1 saturates
		'{'{MODE_SUB, 5'd1, 4'd1, 16'd1, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd1, 4'd1, 16'd1, 1'b1, 1'b0, 1'b0, 1'b1}},
		'{'{MODE_SUB, 5'd2, 4'd1, 16'd1, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd1, 4'd1, 16'd1, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_SUB, 5'd1, 4'd3, 16'd2000, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd29, 4'd2, 16'd2000, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_SUB, 5'd1, 4'd3, 16'd1900, 16'd1, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd28, 4'd2, 16'd1900, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_SUB, 5'd31, 4'd12, 16'hffff, 16'hffff, 5'd0, 4'd0, 16'd0}, 1'b0, '0},
		'{'{MODE_SUB, 5'd0, 4'd13, 16'd5, 16'd7, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd0, 4'd13, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_SUB, 5'd10, 4'd10, 16'd10, 16'd0, 5'd0, 4'd0, 16'd0}, 1'b1,
			'{5'd10, 4'd10, 16'd10, 1'b1, 1'b0, 1'b0, 1'b0}},
		// compare: equal, less across a year end, greater, raw invalid fields
		'{'{MODE_CMP, 5'd1, 4'd1, 16'd2000, 16'd0, 5'd1, 4'd1, 16'd2000}, 1'b1,
			'{5'd1, 4'd1, 16'd2000, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{'{MODE_CMP, 5'd31, 4'd12, 16'd1999, 16'd0, 5'd1, 4'd1, 16'd2000}, 1'b1,
			'{5'd31, 4'd12, 16'd1999, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{'{MODE_CMP, 5'd2, 4'd1, 16'd2000, 16'd500, 5'd1, 4'd1, 16'd2000}, 1'b1,
			'{5'd2, 4'd1, 16'd2000, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{MODE_CMP, 5'd0, 4'd15, 16'd0, 16'd0, 5'd31, 4'd0, 16'hffff}, 1'b1,
			'{5'd0, 4'd15, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}}
	};

	// ------------------------------------------------------------------
	// Random words: mostly real dates with small counts, some noise
	// ------------------------------------------------------------------
	function automatic date_word_t random_word();
		date_word_t w;
		w.mode = 2'($urandom_range(3));
		if ($urandom_range(99) < 80) begin
			case ($urandom_range(4))
				0: w.year = YEAR_W'($urandom_range(1, 3000));
				1: w.year = YEAR_W'($urandom_range(1, YEAR_TOP));
				2: w.year = YEAR_W'($urandom_range(1, 12));	// near the bottom
				3: w.year = YEAR_TOP - YEAR_W'($urandom_range(3));	// near the top
				default: w.year = YEAR_W'(400 * $urandom_range(1, 20) + 100 * $urandom_range(3));
			endcase
			w.month = 4'($urandom_range(1, 12));
			w.day = 5'($urandom_range(1, month_length(w.month, w.year)));
			// lean on the end of February; day 29 may be invalid here
			if ($urandom_range(5) == 0) begin
				w.month = 4'd2;
				w.day = 5'd28 + 5'($urandom_range(1));
			end
		end else begin
			w.day = 5'($urandom);
			w.month = 4'($urandom);
			w.year = ($urandom_range(3) == 0) ? '0 : YEAR_W'($urandom);
		end
		// big counts walk thousands of months, so keep them rare
		case ($urandom_range(19))
			0: w.count = '0;
			1, 2: w.count = COUNT_W'($urandom);
			default: w.count = COUNT_W'($urandom_range(1, 900));
		endcase
		// second date: same, one bit off, or raw
		w.other_day = w.day;
		w.other_month = w.month;
		w.other_year = w.year;
		case ($urandom_range(3))
			0: ;
			1: begin
				case ($urandom_range(2))
					0: w.other_day[0] = ~w.other_day[0];
					1: w.other_month[0] = ~w.other_month[0];
					default: w.other_year[0] = ~w.other_year[0];
				endcase
			end
			default: begin
				w.other_day = 5'($urandom);
				w.other_month = 4'($urandom);
				w.other_year = YEAR_W'($urandom);
			end
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Sender side: called at a falling edge, returns at a falling edge
	// ------------------------------------------------------------------
	task automatic offer_word(input date_word_t w, input logic known, input date_result_t typed);
		in_valid <= 1'b1;
		mode <= w.mode;
		day <= w.day;
		month <= w.month;
		year <= w.year;
		day_count <= w.count;
		other_day <= w.other_day;
		other_month <= w.other_month;
		other_year <= w.other_year;
		// hold the word until the unit takes it
		do
			@(posedge clk);
		while (in_stall);
		expected_dates.push_back(known ? typed : predict_date_op(w));
		@(negedge clk);
	endtask

	// random gaps between words unless no_gaps is set: a gap starts and runs on with a chance of 36 in 100
	task automatic sender_gap();
		if (!no_gaps && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while (!no_gaps && $urandom_range(99) < 36);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_VALIDATE;
		day = '0;
		month = '0;
		year = '0;
		day_count = '0;
		other_day = '0;
		other_month = '0;
		other_year = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probe_rows[i]) begin
			offer_word(probe_rows[i].word, probe_rows[i].known, probe_rows[i].want);
			sender_gap();
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// a stretch with no gaps on either side
			no_gaps = (i >= 90) && (i < 150);
			offer_word(random_word(), 1'b0, '0);
			sender_gap();
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		// drain, then watch for stray words
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver side: random stalls plus one long hold-off once results flow,
	// so the unit backs up into its input while the sender keeps offering
	// ------------------------------------------------------------------
	initial begin : receiver
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && dates_returned >= 60) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_gaps && ($urandom_range(99) < 36);
			end
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("%0t ns: date mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			dates_returned++;
			if (expected_dates.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want_date = expected_dates.pop_front();
				check_field("result_day", 32'(result_day), 32'(want_date.day));
				check_field("result_month", 32'(result_month), 32'(want_date.month));
				check_field("result_year", 32'(result_year), 32'(want_date.year));
				check_field("date_ok", 32'(date_ok), 32'(want_date.ok));
				check_field("is_less", 32'(is_less), 32'(want_date.less));
				check_field("is_equal", 32'(is_equal), 32'(want_date.equal));
				check_field("year_overflow", 32'(year_overflow), 32'(want_date.ovf));
			end
		end
	end

	// hang guard
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
